// ----- sv/pbsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbsr_pkg
// Types and constants shared by the polyphase block-sum store and its
// multiply-add unit.
// ----------------------------------------------------------------------------
package pbsr_pkg;

	localparam int KERNEL_SIZE_DEF = 16;
	localparam int SUBDIV_DEF      = 2;
	localparam int MAX_PLANES_DEF  = 16;

	// shared multiply-add operand width
	localparam int MAC_W = 16;
	localparam int RES_W = 2 * MAC_W;

	// reciprocal split of the kernel index
	localparam int KDIV_SH = 16;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 18;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_TOP,
		ST_LEFT,
		ST_PROW,
		ST_BASE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN
	} pbsr_state_t;

	typedef struct packed {
		logic [MAC_W-1:0] a;
		logic [MAC_W-1:0] b;
		logic [MAC_W-1:0] c;
	} mac_op_t;

endpackage
`default_nettype wire

// ----- sv/pbsr_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbsr_mac
// Shared unsigned multiply-add: res = a * b + c.
// ----------------------------------------------------------------------------
module pbsr_mac (
	input  var pbsr_pkg::mac_op_t             op,
	output logic [pbsr_pkg::RES_W-1:0]        res
);
	import pbsr_pkg::*;

	always_comb begin
		res = RES_W'(op.a) * RES_W'(op.b) + RES_W'(op.c);
	end

endmodule
`default_nettype wire

// ----- sv/polyphase_block_sum_reorg_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphase_block_sum_reorg_top
// Supersampled PSF store with polyphase SUBDIV x SUBDIV block sums.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A load beat keeps the
// block busy through the row index, address and write steps; the next beat is
// taken once it is idle again. A valid query keeps it busy through six
// steps of the shared multiply-add unit to split the kernel index and form the
// base address, then one read per cycle from the single-port sample memory and
// a drain step for the last read to land. done pulses for one cycle with
// block_sum on the cycle busy drops; the receiver cannot stall it. A query
// with an out-of-range plane, phase or kernel index is answered with zero in
// the cycle after it is taken and busy never rises. Loads outside the volume
// are dropped. The memory comes up undefined and is not cleared: every sample
// must be loaded before a query touches it.
// ----------------------------------------------------------------------------
module polyphase_block_sum_reorg_top #(
	parameter int KERNEL_SIZE = pbsr_pkg::KERNEL_SIZE_DEF,
	parameter int SUBDIV      = pbsr_pkg::SUBDIV_DEF,
	parameter int MAX_PLANES  = pbsr_pkg::MAX_PLANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [3:0]  plane,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic [15:0] sample,
	input  logic [1:0]  phase,
	input  logic [7:0]  kernel_index,
	output logic        done,
	output logic [17:0] block_sum
);
	import pbsr_pkg::*;

	localparam int SIDE    = SUBDIV * (KERNEL_SIZE + 1) - 1;
	localparam int DEPTH   = MAX_PLANES * SIDE * SIDE;
	localparam int AW      = $clog2(DEPTH);
	localparam int CNT_W   = (SUBDIV > 1) ? $clog2(SUBDIV) : 1;
	localparam int KDIV_M  = (1 << KDIV_SH) / KERNEL_SIZE;
	localparam int ROW_STEP = SIDE - SUBDIV + 1;

	pbsr_state_t state_q, state_nxt;

	logic              accept;
	logic              load_ok;
	logic              query_ok;
	logic              pl;
	logic [MAC_W-1:0]  pc;

	logic              qry_q;
	logic [3:0]        plane_q;
	logic [7:0]        kidx_q;
	logic [7:0]        q0_q;
	logic [7:0]        kr_q;
	logic [7:0]        kc_q;
	logic [MAC_W-1:0]  r_q;
	logic [MAC_W-1:0]  c_q;
	logic [MAC_W-1:0]  ridx_q;
	logic [AW-1:0]     addr_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [CNT_W-1:0]  dx_q;
	logic [CNT_W-1:0]  dy_q;
	logic              last_rd;

	logic [SAMPLE_W-1:0] rdata_s1;
	logic              rd_v_s1;
	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  sum_q;
	logic              done_q;

	logic [SAMPLE_W-1:0] mem [DEPTH];

	mac_op_t           mac_op;
	logic [RES_W-1:0]  mac_res;
	logic              ram_we;

	logic [7:0]        r0;
	logic              r0_over;

	pbsr_mac u_mac (
		.op  (mac_op),
		.res (mac_res)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);
	assign done      = done_q;
	assign block_sum = sum_q;

	assign load_ok  = (32'(plane) < 32'(MAX_PLANES)) && (32'(row) < 32'(SIDE)) &&
			(32'(col) < 32'(SIDE));
	assign query_ok = (32'(plane) < 32'(MAX_PLANES)) &&
			(32'(phase) < 32'(SUBDIV * SUBDIV)) &&
			(32'(kernel_index) < 32'(KERNEL_SIZE * KERNEL_SIZE));

	// valid phases stay below SUBDIV*SUBDIV; one compare and subtract splits them only while SUBDIV is at most 2
	assign pl = (32'(phase) >= 32'(SUBDIV));
	assign pc = MAC_W'(phase) - (pl ? MAC_W'(SUBDIV) : MAC_W'(0));

	// remainder after the reciprocal estimate; the estimate is at most one low
	assign r0      = kidx_q - mac_res[7:0];
	assign r0_over = (32'(r0) >= 32'(KERNEL_SIZE));

	assign last_rd = (dx_q == CNT_W'(SUBDIV - 1)) && (dy_q == CNT_W'(SUBDIV - 1));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_LOAD)
						state_nxt = load_ok ? ST_PROW : ST_IDLE;
					else
						state_nxt = query_ok ? ST_DIV : ST_IDLE;
				end
			end
			ST_DIV:   state_nxt = ST_REM;
			ST_REM:   state_nxt = ST_TOP;
			ST_TOP:   state_nxt = ST_LEFT;
			ST_LEFT:  state_nxt = ST_PROW;
			ST_PROW:  state_nxt = ST_BASE;
			ST_BASE:  state_nxt = qry_q ? ST_READ : ST_WRITE;
			ST_WRITE: state_nxt = ST_IDLE;
			ST_READ:  state_nxt = last_rd ? ST_DRAIN : ST_READ;
			ST_DRAIN: state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// shared unit operands and memory strobes
	always_comb begin
		mac_op = '0;
		ram_we = 1'b0;
		case (state_q)
			ST_DIV: begin
				mac_op.a = MAC_W'(kidx_q);
				mac_op.b = MAC_W'(KDIV_M);
			end
			ST_REM: begin
				mac_op.a = MAC_W'(q0_q);
				mac_op.b = MAC_W'(KERNEL_SIZE);
			end
			ST_TOP: begin
				mac_op.a = MAC_W'(kr_q);
				mac_op.b = MAC_W'(SUBDIV);
				mac_op.c = r_q;
			end
			ST_LEFT: begin
				mac_op.a = MAC_W'(kc_q);
				mac_op.b = MAC_W'(SUBDIV);
				mac_op.c = c_q;
			end
			ST_PROW: begin
				mac_op.a = MAC_W'(plane_q);
				mac_op.b = MAC_W'(SIDE);
				mac_op.c = r_q;
			end
			ST_BASE: begin
				mac_op.a = ridx_q;
				mac_op.b = MAC_W'(SIDE);
				mac_op.c = c_q;
			end
			ST_WRITE: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			rd_v_s1 <= 1'b0;
			qry_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rd_v_s1 <= (state_q == ST_READ);
			done_q  <= (state_q == ST_DRAIN) ||
					(accept && (action == ACT_QUERY) && !query_ok);
			if (accept)
				qry_q <= (action == ACT_QUERY);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			plane_q  <= plane;
			kidx_q   <= kernel_index;
			sample_q <= sample;
			acc_q    <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			if (action == ACT_LOAD) begin
				r_q <= MAC_W'(row);
				c_q <= MAC_W'(col);
			end else begin
				r_q <= MAC_W'(SUBDIV - 1) - MAC_W'(pl);
				c_q <= MAC_W'(SUBDIV - 1) - pc;
			end
			if (!query_ok)
				sum_q <= '0;
		end else begin
			if (rd_v_s1)
				acc_q <= acc_q + SUM_W'(rdata_s1);
			case (state_q)
				ST_DIV: q0_q <= mac_res[KDIV_SH+7:KDIV_SH];
				ST_REM: begin
					kr_q <= r0_over ? q0_q + 8'd1 : q0_q;
					kc_q <= r0_over ? r0 - 8'(KERNEL_SIZE) : r0;
				end
				ST_TOP:  r_q    <= mac_res[MAC_W-1:0];
				ST_LEFT: c_q    <= mac_res[MAC_W-1:0];
				ST_PROW: ridx_q <= mac_res[MAC_W-1:0];
				ST_BASE: addr_q <= mac_res[AW-1:0];
				ST_READ: begin
					if (dx_q == CNT_W'(SUBDIV - 1)) begin
						dx_q   <= '0;
						dy_q   <= dy_q + CNT_W'(1);
						addr_q <= addr_q + AW'(ROW_STEP);
					end else begin
						dx_q   <= dx_q + CNT_W'(1);
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: sum_q <= acc_q + SUM_W'(rdata_s1);
				default: ;
			endcase
		end
	end

	// single-port sample memory, registered read
	always_ff @(posedge clk) begin
		if (ram_we)
			mem[addr_q] <= sample_q;
		else
			rdata_s1 <= mem[addr_q];
	end

endmodule
`default_nettype wire
